// ===== hdl/lse_pkg.sv =====
package lse_pkg;

   localparam int PALETTE_SIZE = 256;
   localparam int WIDTH_MAX    = 8192;

   localparam int PAL_AW = $clog2(PALETTE_SIZE);
   localparam int CNT_W  = $clog2(PALETTE_SIZE + 1);
   localparam int COL_W  = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;
   localparam int MAP_DEPTH = 256;

   localparam logic [1:0] OP_LOAD      = 2'd0;
   localparam logic [1:0] OP_IMAGE     = 2'd1;
   localparam logic [1:0] OP_NEW_IMAGE = 2'd2;

   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_BPP       = 2'd1;
   localparam logic [1:0] CSR_ROW_WIDTH = 2'd2;
   localparam logic [1:0] CSR_MAX_LEN   = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [2:0]  bytes_per_pixel;
      logic [13:0] row_width;
      logic [15:0] max_length;
   } lse_cfg_type;

   typedef struct packed {
      logic        load;
      logic        clear;
      logic [23:0] colour;
      logic [7:0]  lookup_addr;
   } lse_pt_cmd_type;

   typedef struct packed {
      logic busy;
      logic lk_paired;
      logic lk_higher;
   } lse_pt_stat_type;

   typedef struct packed {
      logic       image;
      logic       clear;
      logic [7:0] data_byte;
   } lse_st_cmd_type;

endpackage

// ===== hdl/lse_channels.sv =====
interface lse_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, operation, data_byte, red, green, blue, input ready);
   modport sink   (input valid, operation, data_byte, red, green, blue, output ready);
endinterface

interface lse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] secret_char;
   logic       last;

   modport source (output valid, secret_char, last, input ready);
   modport sink   (input valid, secret_char, last, output ready);
endinterface

// ===== hdl/lse_ram.sv =====
module lse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lse_pair_table.sv =====
module lse_pair_table import lse_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lse_pt_cmd_type  cmd,
   output lse_pt_stat_type stat
);

   localparam logic [1:0] PT_IDLE = 2'd0;
   localparam logic [1:0] PT_WALK = 2'd1;
   localparam logic [1:0] PT_LINK = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PAL_AW-1:0]    new_ff, new_in;
   logic [23:0]          colour_ff, colour_in;
   logic [PAL_AW-1:0]    issue_ff, issue_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [PAL_AW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [MAP_DEPTH-1:0] paired_ff, paired_in;
   logic [7:0]           lk_byte_ff;
   logic                 lk_paired_ff;

   logic        full;
   logic        issuing;
   logic        hit;
   logic [7:0]  new8;
   logic [7:0]  cmp8;
   logic        col_wr_en;
   logic [23:0] col_rd_data;
   logic        map_wr_en;
   logic [7:0]  map_wr_addr;
   logic [7:0]  map_wr_data;
   logic [7:0]  map_rd_data;

   assign full    = (count_ff == CNT_W'(PALETTE_SIZE));
   assign issuing = (issue_ff != new_ff);
   assign new8    = 8'(new_ff);
   assign cmp8    = 8'(cmp_idx_ff);
   assign hit     = (state_ff == PT_WALK) && cmp_valid_ff &&
                    (col_rd_data == colour_ff) && !paired_ff[cmp8];

   assign col_wr_en   = (state_ff == PT_IDLE) && cmd.load && !cmd.clear && !full;
   assign map_wr_en   = hit || (state_ff == PT_LINK);
   assign map_wr_addr = (state_ff == PT_LINK) ? cmp8 : new8;
   assign map_wr_data = (state_ff == PT_LINK) ? new8 : cmp8;

   lse_ram #(.WIDTH(24), .DEPTH(PALETTE_SIZE)) u_colour_ram (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (count_ff[PAL_AW-1:0]),
      .wr_data (cmd.colour),
      .rd_addr (issue_ff),
      .rd_data (col_rd_data)
   );

   lse_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_pair_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (cmd.lookup_addr),
      .rd_data (map_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      new_in       = new_ff;
      colour_in    = colour_ff;
      issue_in     = issue_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      paired_in    = paired_ff;
      if (cmd.clear) begin
         state_in     = PT_IDLE;
         count_in     = '0;
         cmp_valid_in = 1'b0;
         paired_in    = '0;
      end else begin
         case (state_ff)
            PT_IDLE: begin
               if (cmd.load && !full) begin
                  if (count_ff == '0) begin
                     count_in = count_ff + 1'b1;
                  end else begin
                     state_in     = PT_WALK;
                     new_in       = count_ff[PAL_AW-1:0];
                     colour_in    = cmd.colour;
                     issue_in     = '0;
                     cmp_valid_in = 1'b0;
                  end
               end
            end
            PT_WALK: begin
               if (hit) begin
                  // Earliest free match found: link both entries, second write follows.
                  paired_in[new8] = 1'b1;
                  paired_in[cmp8] = 1'b1;
                  cmp_valid_in    = 1'b0;
                  state_in        = PT_LINK;
               end else if (issuing) begin
                  issue_in     = issue_ff + 1'b1;
                  cmp_valid_in = 1'b1;
                  cmp_idx_in   = issue_ff;
               end else if (cmp_valid_ff) begin
                  cmp_valid_in = 1'b0;
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = PT_IDLE;
               end
            end
            PT_LINK: begin
               count_in = count_ff + 1'b1;
               state_in = PT_IDLE;
            end
            default: begin
               state_in = PT_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PT_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         paired_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         paired_ff    <= paired_in;
      end
      new_ff       <= new_in;
      colour_ff    <= colour_in;
      issue_ff     <= issue_in;
      cmp_idx_ff   <= cmp_idx_in;
      lk_byte_ff   <= cmd.lookup_addr;
      lk_paired_ff <= paired_ff[cmd.lookup_addr];
   end

   assign stat.busy      = (state_ff != PT_IDLE);
   assign stat.lk_paired = lk_paired_ff;
   assign stat.lk_higher = (lk_byte_ff > map_rd_data);

endmodule

// ===== hdl/lse_stream.sv =====
module lse_stream import lse_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lse_cfg_type     cfg,
   input  lse_st_cmd_type  cmd,
   input  lse_pt_stat_type pt_stat,
   output logic            busy,
   output logic [7:0]      lookup_addr,
   lse_rsp_if.source       rsp
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic             state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [1:0]       cp_ff, cp_in;
   logic             filter_ff, filter_in;
   logic [7:0]       buf_ff, buf_in;
   logic [2:0]       bitcnt_ff, bitcnt_in;
   logic [15:0]      chars_ff, chars_in;
   logic             finished_ff, finished_in;
   logic [7:0]       byte_ff, byte_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [2:0]  bpp_eff;
   logic [16:0] width_eff;
   logic [15:0] limit;
   logic [1:0]  cp_cur;
   logic [2:0]  cp_next;
   logic [16:0] col_next;
   logic        have_bit;
   logic        bit_val;
   logic        emit;
   logic        rsp_busy;
   logic        commit;
   logic [7:0]  buf_new;
   logic [15:0] chars_new;
   logic        last_new;

   always_comb begin
      bpp_eff = cfg.bytes_per_pixel;
      if (bpp_eff == 3'd0) begin
         bpp_eff = 3'd1;
      end
      if (bpp_eff > 3'd4) begin
         bpp_eff = 3'd4;
      end
      if (cfg.mode) begin
         bpp_eff = 3'd1;
      end
      width_eff = 17'(cfg.row_width);
      if (width_eff == 17'd0) begin
         width_eff = 17'd1;
      end
      if (width_eff > 17'(WIDTH_MAX)) begin
         width_eff = 17'(WIDTH_MAX);
      end
      limit = (cfg.max_length == 16'd0) ? 16'd1 : cfg.max_length;
   end

   assign cp_cur   = ({1'b0, cp_ff} >= bpp_eff) ? 2'd0 : cp_ff;
   assign cp_next  = {1'b0, cp_cur} + 3'd1;
   assign col_next = 17'(col_ff) + 17'd1;

   assign have_bit  = cfg.mode ? pt_stat.lk_paired : 1'b1;
   assign bit_val   = cfg.mode ? pt_stat.lk_higher : byte_ff[0];
   assign emit      = (state_ff == ST_LOOKUP) && have_bit && (bitcnt_ff == 3'd7);
   assign rsp_busy  = rsp_valid_ff && !rsp.ready;
   assign commit    = (state_ff == ST_LOOKUP) && have_bit && !(emit && rsp_busy);
   assign buf_new   = buf_ff | (8'(bit_val) << bitcnt_ff);
   assign chars_new = chars_ff + 16'd1;
   assign last_new  = (buf_new == 8'd0) || (chars_new >= limit);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      cp_in        = cp_ff;
      filter_in    = filter_ff;
      buf_in       = buf_ff;
      bitcnt_in    = bitcnt_ff;
      chars_in     = chars_ff;
      finished_in  = finished_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.clear) begin
               col_in      = '0;
               cp_in       = 2'd0;
               filter_in   = 1'b1;
               buf_in      = 8'd0;
               bitcnt_in   = 3'd0;
               chars_in    = 16'd0;
               finished_in = 1'b0;
            end else if (cmd.image && !finished_ff) begin
               if (filter_ff) begin
                  filter_in = 1'b0;
               end else begin
                  if (cp_cur == 2'd0) begin
                     state_in = ST_LOOKUP;
                     byte_in  = cmd.data_byte;
                  end
                  if (cp_next >= bpp_eff) begin
                     cp_in = 2'd0;
                     if (col_next >= width_eff) begin
                        col_in    = '0;
                        filter_in = 1'b1;
                     end else begin
                        col_in = col_next[COL_W-1:0];
                     end
                  end else begin
                     cp_in = cp_next[1:0];
                  end
               end
            end
         end
         ST_LOOKUP: begin
            if (!have_bit) begin
               state_in = ST_IDLE;
            end else if (commit) begin
               state_in = ST_IDLE;
               if (emit) begin
                  buf_in       = 8'd0;
                  bitcnt_in    = 3'd0;
                  chars_in     = chars_new;
                  finished_in  = last_new;
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = buf_new;
                  rsp_last_in  = last_new;
               end else begin
                  buf_in    = buf_new;
                  bitcnt_in = bitcnt_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         cp_ff        <= 2'd0;
         filter_ff    <= 1'b1;
         buf_ff       <= 8'd0;
         bitcnt_ff    <= 3'd0;
         chars_ff     <= 16'd0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         cp_ff        <= cp_in;
         filter_ff    <= filter_in;
         buf_ff       <= buf_in;
         bitcnt_ff    <= bitcnt_in;
         chars_ff     <= chars_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff     <= byte_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy        = (state_ff == ST_LOOKUP);
   assign lookup_addr = (state_ff == ST_LOOKUP) ? byte_ff : cmd.data_byte;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.secret_char = rsp_char_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

// ===== hdl/lsb_stego_extract_unit.sv =====
// Recovers a hidden message from raw, already inflated scanline bytes. Each request
// carries an operation: load a palette entry, present one image byte, or start a
// new image (which forgets the palette, all pairings and all stream and message
// state, but keeps the configuration registers). Every scanline opens with a
// filter byte that is skipped. In direct mode the LSB of the first byte of each
// pixel is one message bit; in palette mode each pixel is one index byte, and an
// index that was paired at load time with an earlier entry of identical colour
// gives bit 1 when it is the higher index of its pair, bit 0 otherwise, while an
// unpaired index gives no bit. Bits fill characters LSB first; a NUL character or
// reaching max_length characters ends the run with last set, after which image
// bytes are dropped until the next new-image request. An image byte that lands
// on the first byte of a pixel holds off the input during a lookup, because the
// pair-map memory has a registered read; every other image byte, a new-image
// request and a load into an empty or full palette are taken without a hold. A
// palette load into a palette of n entries walks the colour memory one entry per
// cycle. Pairing flags live in flip-flops and clear in the same cycle as a
// new-image request, so there is no clearing pass after reset. A finished
// character sits in an output register, so the next request is taken while it
// waits; only a character that completes while the previous one is still unread
// holds the block. Configuration registers are written through csr_we, csr_index
// and csr_wdata, and should only be written while the block is idle.
module lsb_stego_extract_unit import lse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lse_req_if.sink     req_chan,
   lse_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   lse_cfg_type     cfg_ff;
   lse_pt_cmd_type  pt_cmd;
   lse_pt_stat_type pt_stat;
   lse_st_cmd_type  st_cmd;
   logic            st_busy;
   logic [7:0]      lookup_addr;
   logic            accept;

   // Configuration registers, reset to direct mode, one byte per pixel,
   // one pixel per row and a one-character message.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode            <= 1'b0;
         cfg_ff.bytes_per_pixel <= 3'd1;
         cfg_ff.row_width       <= 14'd1;
         cfg_ff.max_length      <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:      cfg_ff.mode            <= csr_wdata[0];
            CSR_BPP:       cfg_ff.bytes_per_pixel <= csr_wdata[2:0];
            CSR_ROW_WIDTH: cfg_ff.row_width       <= csr_wdata[13:0];
            CSR_MAX_LEN:   cfg_ff.max_length      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // A request is taken whenever neither the palette walker nor the pixel
   // lookup is in progress.
   assign req_chan.ready = !pt_stat.busy && !st_busy;
   assign accept         = req_chan.valid && req_chan.ready;

   assign pt_cmd.load        = accept && (req_chan.operation == OP_LOAD);
   assign pt_cmd.clear       = accept && (req_chan.operation == OP_NEW_IMAGE);
   assign pt_cmd.colour      = {req_chan.red, req_chan.green, req_chan.blue};
   assign pt_cmd.lookup_addr = lookup_addr;

   assign st_cmd.image     = accept && (req_chan.operation == OP_IMAGE);
   assign st_cmd.clear     = accept && (req_chan.operation == OP_NEW_IMAGE);
   assign st_cmd.data_byte = req_chan.data_byte;

   lse_pair_table u_pair_table (
      .clock (clock),
      .reset (reset),
      .cmd   (pt_cmd),
      .stat  (pt_stat)
   );

   lse_stream u_stream (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (st_cmd),
      .pt_stat     (pt_stat),
      .busy        (st_busy),
      .lookup_addr (lookup_addr),
      .rsp         (rsp_chan)
   );

endmodule

// ===== hdl/lse_checker.sv =====
module lse_checker import lse_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_operation,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_secret_char,
   input logic       rsp_last
);

   // A waiting character holds its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_secret_char) && $stable(rsp_last))
      else $error("response changed or dropped while stalled");

   // A new character shows up once an image byte request was taken and its lookup
   // state has ended, and the input was held off in between by the pending lookup.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2) &&
                           ($past(req_operation, 2) == OP_IMAGE) && !$past(req_ready, 1))
      else $error("response without a matching image byte request");

   // Reset leaves no character pending.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind lsb_stego_extract_unit lse_checker u_lse_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_operation   (req_chan.operation),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_secret_char (rsp_chan.secret_char),
   .rsp_last        (rsp_chan.last)
);
